### src/ffha_pkg.sv
`timescale 1ns / 1ps
// Package for the first-fit heap allocator: command codes and fixed field widths.
// Used by the top level and the checker; depends on nothing.
package ffha_pkg;

    localparam int CMD_W   = 3;
    localparam int REQ_W   = 17;
    localparam int TASK_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int FRAG_W  = 12;
    localparam int CFG_W   = 17;
    localparam int PADDR_W = 3;

    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd4;

    localparam logic [TASK_W-1:0] KERNEL_ID = 8'd255;

    localparam logic [PADDR_W-1:0] REG_HEAP_BYTES = 3'd0;

endpackage

### src/ffha_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module ffha_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit heap allocator with a block table in one RAM.
// Depends on ffha_pkg and ffha_ram.
//
// Channel  | Handshake             | Beat contents
// ---------+-----------------------+-------------------------------------------
// command  | start, busy           | command, req_size, owner, payload_addr, ...
// result   | o_done (one cycle)    | status, alloc_addr, frag_count, heap_ready
// config   | APB psel/penable      | heap_bytes at address 0
//
// A command walks the table entry by entry (read, then check) and moves entries one by
// one (read, then write) when a block is split or merged; the single RAM port pair sets
// this. Init, null frees and commands refused before any walk go straight to the result
// beat. Reset clears the block count and the initialized flag; the table itself needs
// no clearing pass. Results cannot be stalled; busy stays high through the result beat.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 8,
    parameter int MAX_BLOCKS   = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ffha_pkg::CMD_W-1:0]   i_command,
    input  logic [ffha_pkg::REQ_W-1:0]   i_req_size,
    input  logic [ffha_pkg::TASK_W-1:0]  i_owner,
    input  logic [ffha_pkg::ADDR_W-1:0]  i_payload_addr,
    input  logic [ffha_pkg::TASK_W-1:0]  i_caller,
    input  logic                         i_kernel_ready,
    output logic                         o_done,
    output logic                         o_status,
    output logic [ffha_pkg::ADDR_W-1:0]  o_alloc_addr,
    output logic [ffha_pkg::FRAG_W-1:0]  o_frag_count,
    output logic                         o_heap_ready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffha_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int HB_W  = $clog2(HEAP_BYTES + 1);
    localparam int SZ_W  = ((HB_W > ffha_pkg::REQ_W) ? HB_W : ffha_pkg::REQ_W) + 1;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W = SZ_W + 1 + ffha_pkg::TASK_W;

    localparam logic [SZ_W-1:0]  HEAP_MAX   = SZ_W'(HEAP_BYTES);
    localparam logic [SZ_W-1:0]  HDR        = SZ_W'(HEADER_BYTES);
    localparam logic [SZ_W-1:0]  ALIGN_M1   = SZ_W'(ALIGN_BYTES - 1);
    localparam logic [SZ_W-1:0]  MIN_BLOCK  = SZ_W'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_BLOCKS);

    typedef struct packed {
        logic [SZ_W-1:0]             size;
        logic                        used;
        logic [ffha_pkg::TASK_W-1:0] owner;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_RD, S_SPLIT_WR, S_SPLIT_FIN,
        S_SPLIT_FIN2, S_REL_NXT, S_REL_NXTC, S_REL_PRV, S_REL_PRVC, S_REL_WR,
        S_DROP_RD, S_DROP_WR, S_REL_END, S_DONE
    } t_state;

    t_state                      r_state;
    logic [ffha_pkg::CMD_W-1:0]  r_cmd;
    logic [ffha_pkg::REQ_W-1:0]  r_req;
    logic [ffha_pkg::TASK_W-1:0] r_owner;
    logic [ffha_pkg::ADDR_W-1:0] r_paddr;
    logic [ffha_pkg::TASK_W-1:0] r_caller;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            r_idx;
    logic [CNT_W-1:0]            r_j;
    logic [CNT_W-1:0]            r_m;
    logic [1:0]                  r_k;
    logic                        r_init;
    logic [SZ_W-1:0]             r_off;
    logic [SZ_W-1:0]             r_need;
    logic [SZ_W-1:0]             r_rest;
    logic [SZ_W-1:0]             r_sum;
    logic                        r_status;
    logic [ffha_pkg::ADDR_W-1:0] r_addr;
    logic [ffha_pkg::FRAG_W-1:0] r_frag;
    logic [ffha_pkg::CFG_W-1:0]  r_heap;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    t_entry                      wr_data;
    logic [IDX_W-1:0]            rd_addr;
    t_entry                      rd_data;
    logic [ENT_W-1:0]            rd_raw;

    logic                        accept;
    logic [SZ_W-1:0]             heap_clip;
    logic [SZ_W-1:0]             init_size;
    logic                        init_ok;
    logic [SZ_W-1:0]             need;
    logic [SZ_W-1:0]             rest;
    logic                        fit;
    logic                        split;
    logic [ffha_pkg::ADDR_W-1:0] pay_off;
    logic                        free_hit;
    logic                        free_ok;
    logic                        rel_hit;
    logic [CNT_W-1:0]            drop_src;

    ffha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_data = t_entry'(rd_raw);
    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign pready  = 1'b1;
    assign prdata  = (paddr == ffha_pkg::REG_HEAP_BYTES) ? 32'(r_heap) : 32'd0;

    assign o_done       = (r_state == S_DONE);
    assign o_status     = r_status;
    assign o_alloc_addr = r_addr;
    assign o_frag_count = r_frag;
    assign o_heap_ready = r_init;

    assign heap_clip = (SZ_W'(r_heap) > HEAP_MAX) ? HEAP_MAX : SZ_W'(r_heap);
    assign init_size = heap_clip & ~ALIGN_M1;
    assign init_ok   = !r_init && i_kernel_ready && (init_size >= MIN_BLOCK);
    assign need      = ((SZ_W'(i_req_size) + ALIGN_M1) & ~ALIGN_M1) + HDR;

    assign rest     = rd_data.size - r_need;
    assign fit      = !rd_data.used && (rd_data.size >= r_need);
    assign split    = (rest >= MIN_BLOCK) && (r_cnt < CNT_MAX);
    assign pay_off  = ffha_pkg::ADDR_W'(r_off + HDR);
    assign free_hit = rd_data.used && (pay_off == r_paddr);
    assign free_ok  = (r_caller == ffha_pkg::KERNEL_ID) || (rd_data.owner == r_caller);
    assign rel_hit  = rd_data.used && (rd_data.owner == r_owner);
    assign drop_src = r_j + CNT_W'(r_k);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = rd_data;
        rd_addr = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                wr_en   = accept && (i_command == ffha_pkg::CMD_INIT) && init_ok;
                wr_addr = '0;
                wr_data = '{size: init_size, used: 1'b0, owner: ffha_pkg::KERNEL_ID};
            end
            S_SCAN_CHK: begin
                wr_en   = (r_cmd == ffha_pkg::CMD_ALLOC) && fit && !split;
                wr_data = '{size: rd_data.size, used: 1'b1, owner: r_owner};
            end
            S_SPLIT_RD: rd_addr = r_j[IDX_W-1:0];
            S_SPLIT_WR: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_j + 1'b1);
            end
            S_SPLIT_FIN: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_idx + 1'b1);
                wr_data = '{size: r_rest, used: 1'b0, owner: ffha_pkg::KERNEL_ID};
            end
            S_SPLIT_FIN2: begin
                wr_en   = 1'b1;
                wr_data = '{size: r_need, used: 1'b1, owner: r_owner};
            end
            S_REL_NXT: rd_addr = IDX_W'(r_idx + 1'b1);
            S_REL_PRV: rd_addr = IDX_W'(r_idx - 1'b1);
            S_REL_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_m[IDX_W-1:0];
                wr_data = '{size: r_sum, used: 1'b0, owner: ffha_pkg::KERNEL_ID};
            end
            S_DROP_RD: rd_addr = drop_src[IDX_W-1:0];
            S_DROP_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_init   <= 1'b0;
            r_heap   <= ffha_pkg::CFG_W'(65536);
            r_status <= 1'b1;
            r_addr   <= '0;
            r_frag   <= '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ffha_pkg::REG_HEAP_BYTES) begin
                r_heap <= pwdata[ffha_pkg::CFG_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_command;
                        r_req    <= i_req_size;
                        r_owner  <= i_owner;
                        r_paddr  <= i_payload_addr;
                        r_caller <= i_caller;
                        r_need   <= need;
                        r_idx    <= '0;
                        r_off    <= '0;
                        r_status <= 1'b1;
                        r_addr   <= '0;
                        r_frag   <= '0;
                        r_state  <= S_DONE;
                        case (i_command)
                            ffha_pkg::CMD_INIT: begin
                                if (init_ok) begin
                                    r_cnt    <= CNT_W'(1);
                                    r_init   <= 1'b1;
                                    r_status <= 1'b0;
                                end
                            end
                            ffha_pkg::CMD_ALLOC: begin
                                if (r_init && i_req_size != '0) begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            ffha_pkg::CMD_FREE: begin
                                if (r_init && i_payload_addr == '0) begin
                                    r_status <= 1'b0;
                                end else if (r_init) begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            ffha_pkg::CMD_RELEASE: begin
                                if (r_init && i_owner != ffha_pkg::KERNEL_ID) begin
                                    r_status <= 1'b0;
                                    r_state  <= S_SCAN_RD;
                                end
                            end
                            ffha_pkg::CMD_COUNT: begin
                                r_status <= 1'b0;
                                if (r_init) begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    r_state <= (r_idx >= r_cnt) ? S_DONE : S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    r_off   <= r_off + rd_data.size;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SCAN_RD;
                    case (r_cmd)
                        ffha_pkg::CMD_ALLOC: begin
                            if (fit) begin
                                r_addr   <= pay_off;
                                r_off    <= r_off;
                                r_idx    <= r_idx;
                                if (split) begin
                                    r_rest  <= rest;
                                    r_j     <= r_cnt - 1'b1;
                                    r_state <= (r_cnt - 1'b1 == r_idx) ? S_SPLIT_FIN
                                                                       : S_SPLIT_RD;
                                end else begin
                                    r_status <= 1'b0;
                                    r_state  <= S_DONE;
                                end
                            end
                        end
                        ffha_pkg::CMD_FREE: begin
                            if (free_hit) begin
                                r_idx <= r_idx;
                                if (free_ok) begin
                                    r_sum   <= rd_data.size;
                                    r_m     <= r_idx;
                                    r_k     <= '0;
                                    r_state <= S_REL_NXT;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                        end
                        ffha_pkg::CMD_RELEASE: begin
                            if (rel_hit) begin
                                r_idx   <= r_idx;
                                r_sum   <= rd_data.size;
                                r_m     <= r_idx;
                                r_k     <= '0;
                                r_state <= S_REL_NXT;
                            end
                        end
                        default: begin
                            if (!rd_data.used && rd_data.size < SZ_W'(r_req)) begin
                                r_frag <= r_frag + 1'b1;
                            end
                        end
                    endcase
                end
                S_SPLIT_RD: r_state <= S_SPLIT_WR;
                S_SPLIT_WR: begin
                    if (r_j == r_idx + 1'b1) begin
                        r_state <= S_SPLIT_FIN;
                    end else begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_SPLIT_RD;
                    end
                end
                S_SPLIT_FIN: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_SPLIT_FIN2;
                end
                S_SPLIT_FIN2: begin
                    r_status <= 1'b0;
                    r_state  <= S_DONE;
                end
                S_REL_NXT: r_state <= (r_idx + 1'b1 < r_cnt) ? S_REL_NXTC : S_REL_PRV;
                S_REL_NXTC: begin
                    if (!rd_data.used) begin
                        r_sum <= r_sum + rd_data.size;
                        r_k   <= 2'd1;
                    end
                    r_state <= S_REL_PRV;
                end
                S_REL_PRV: r_state <= (r_idx != '0) ? S_REL_PRVC : S_REL_WR;
                S_REL_PRVC: begin
                    if (!rd_data.used) begin
                        r_sum <= r_sum + rd_data.size;
                        r_m   <= r_idx - 1'b1;
                        r_k   <= r_k + 1'b1;
                    end
                    r_state <= S_REL_WR;
                end
                S_REL_WR: begin
                    r_j     <= r_m + 1'b1;
                    r_state <= (r_k == '0) ? S_REL_END : S_DROP_RD;
                end
                S_DROP_RD: begin
                    if (drop_src >= r_cnt) begin
                        r_cnt   <= r_cnt - CNT_W'(r_k);
                        r_state <= S_REL_END;
                    end else begin
                        r_state <= S_DROP_WR;
                    end
                end
                S_DROP_WR: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_DROP_RD;
                end
                S_REL_END: begin
                    if (r_cmd == ffha_pkg::CMD_FREE) begin
                        r_status <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= r_m + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### src/ffha_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the first-fit heap allocator, bound to its top level.
// Depends on ffha_pkg and first_fit_heap_allocator.
module ffha_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic                         o_status,
    input logic [ffha_pkg::ADDR_W-1:0]  o_alloc_addr,
    input logic [ffha_pkg::FRAG_W-1:0]  o_frag_count,
    input logic                         o_heap_ready
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Accepted command did not raise busy.");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("Result beat lasted more than one cycle.");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("Result beat shown while not busy.");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status || !o_heap_ready) |-> o_alloc_addr == '0)
        else $error("Nonzero address on a failed result.");

    a_frag_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_frag_count != '0 |-> o_heap_ready && !o_status)
        else $error("Fragment count on an uninitialized heap or error.");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_alloc_addr (o_alloc_addr),
    .o_frag_count (o_frag_count),
    .o_heap_ready (o_heap_ready)
);
